// File: hdl/bitv_pkg.sv
`timescale 1ns / 1ps

package bitv_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned COUNT_W = 13;
   localparam int unsigned FAULT_W = 4;
   localparam int unsigned SLOT_W  = 18;
   localparam int unsigned INDEX_W = 3;
   localparam int unsigned RSP_W   = 40;

   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [FAULT_W-1:0] fault_type;
   typedef logic [SLOT_W-1:0]  slot_type;
   typedef logic [INDEX_W-1:0] index_type;
   typedef logic [RSP_W-1:0]   rsp_type;
   typedef word_type crc_cols_type [WORD_W];

   localparam word_type  MAX_IMAGE_BYTES = 32'd16384;
   localparam word_type  CRC_POLY  = 32'hEDB8_8320;
   localparam word_type  ALL_ONES  = 32'hFFFF_FFFF;
   localparam word_type  SIG_WORD  = 32'h4C42_424E;
   localparam word_type  SRAM_LO   = 32'h2000_0000;
   localparam word_type  SRAM_HI   = 32'h2000_4000;
   localparam word_type  SLOT_SIZE = 32'h0000_4000;
   localparam word_type  SLOT_BASE = 32'h0003_C000;
   localparam word_type  SLOT_END  = SLOT_BASE + SLOT_SIZE;
   localparam count_type COUNT_MAX = {COUNT_W{1'b1}};

   localparam fault_type F_OK     = 4'd0;
   localparam fault_type F_MAGIC  = 4'd1;
   localparam fault_type F_COMPL  = 4'd2;
   localparam fault_type F_LENGTH = 4'd3;
   localparam fault_type F_SLOT   = 4'd4;
   localparam fault_type F_CRC    = 4'd5;
   localparam fault_type F_STACK  = 4'd6;
   localparam fault_type F_THUMB  = 4'd7;
   localparam fault_type F_VECTOR = 4'd8;
   localparam fault_type F_COUNT  = 4'd9;

   localparam index_type REG_MAGIC  = 3'd0;
   localparam index_type REG_LENGTH = 3'd1;
   localparam index_type REG_COMPL  = 3'd2;
   localparam index_type REG_CRC    = 3'd3;
   localparam index_type REG_ROOM   = 3'd4;

   // column j: CRC image of a lone one in bit j after 32 shift steps
   function automatic crc_cols_type crc_columns();
      crc_cols_type cols;
      word_type     c;
      for (int j = 0; j < WORD_W; j++) begin
         c = word_type'(1) << j;
         for (int k = 0; k < WORD_W; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
         end
         cols[j] = c;
      end
      return cols;
   endfunction

   localparam crc_cols_type CRC_COLS = crc_columns();

   function automatic word_type crc_fold(word_type crc, word_type w);
      word_type x;
      word_type acc;
      x   = crc ^ w;
      acc = '0;
      for (int j = 0; j < WORD_W; j++) begin
         if (x[j]) begin
            acc = acc ^ CRC_COLS[j];
         end
      end
      return acc;
   endfunction

endpackage

// File: hdl/boot_image_trailer_verifier_unit.sv
`timescale 1ns / 1ps

// Boot image trailer verifier.
// Load the trailer through the csr_ port (index 0 magic, 1 length, 2 length
// complement, 3 expected CRC, 4 slot room) while the block is idle.
// Stream the image on req_: req_tdata carries one 32-bit image word, bytes
// little-endian, and req_tlast marks the final word. Every word is folded
// into a reflected CRC-32; word 0 is checked as a stack pointer, word 1 as
// a thumb reset vector.
// On the final word one result word leaves on rsp_: pass flag, fault code
// and the inverted CRC. Other words give no result.
// A word accepted on req_ sits in the input register; the result of a final
// word is then loaded into the output register. Throughput is one word per
// cycle while no final word is held, set by the combinational parallel CRC update.
// When rsp_tready is low and a result waits, a final word in the input
// register holds and req_tready drops; non-final words keep flowing.
// Reset (synchronous, active high) clears the trailer registers to zero,
// presets the CRC to all ones and empties both registers.

module boot_image_trailer_verifier_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  bitv_pkg::index_type      csr_index,
   input  bitv_pkg::word_type       csr_wdata,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  bitv_pkg::word_type       req_tdata,   // [31:0] image_word
   input  logic                     req_tlast,   // last_word
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output bitv_pkg::rsp_type        rsp_tdata    // [0] image_ok, [4:1] fault_code,
                                                 // [36:5] computed_crc, [39:37] zero
);
   import bitv_pkg::*;

   word_type  magic_ff, length_ff, compl_ff, exp_crc_ff;
   slot_type  room_ff;

   logic      s1_valid_ff, s1_valid_in;
   word_type  s1_word_ff, s1_word_in;
   logic      s1_last_ff, s1_last_in;

   word_type  crc_ff, crc_in;
   count_type words_ff, words_in;
   fault_type fault_ff, fault_in;

   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff, rsp_data_in;

   logic      s1_fire;
   word_type  crc_next;
   word_type  crc_out;
   count_type words_next;
   fault_type vf;
   fault_type ff_next;
   fault_type code;
   word_type  vec_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff   <= '0;
         length_ff  <= '0;
         compl_ff   <= '0;
         exp_crc_ff <= '0;
         room_ff    <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_MAGIC:  magic_ff   <= csr_wdata;
            REG_LENGTH: length_ff  <= csr_wdata;
            REG_COMPL:  compl_ff   <= csr_wdata;
            REG_CRC:    exp_crc_ff <= csr_wdata;
            REG_ROOM:   room_ff    <= csr_wdata[SLOT_W-1:0];
            default:    ;
         endcase
      end
   end

   assign s1_fire    = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_word_in  = s1_word_ff;
      s1_last_in  = s1_last_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
         s1_word_in  = req_tdata;
         s1_last_in  = req_tlast;
      end
   end

   always_comb begin
      crc_next   = crc_fold(crc_ff, s1_word_ff);
      crc_out    = crc_next ^ ALL_ONES;
      words_next = (words_ff == COUNT_MAX) ? words_ff : words_ff + count_type'(1);
      vec_addr   = {s1_word_ff[WORD_W-1:1], 1'b0};

      vf = F_OK;
      if (words_ff == count_type'(0)) begin
         if (s1_word_ff < SRAM_LO || s1_word_ff > SRAM_HI) begin
            vf = F_STACK;
         end
      end else if (words_ff == count_type'(1)) begin
         if (!s1_word_ff[0]) begin
            vf = F_THUMB;
         end else if (vec_addr < SLOT_BASE || vec_addr >= SLOT_END) begin
            vf = F_VECTOR;
         end
      end

      ff_next = (fault_ff == F_OK) ? vf : fault_ff;
      if (s1_last_ff && ff_next == F_OK && words_next < count_type'(2)) begin
         ff_next = F_VECTOR;
      end

      if (magic_ff != SIG_WORD) begin
         code = F_MAGIC;
      end else if ((length_ff ^ ALL_ONES) != compl_ff) begin
         code = F_COMPL;
      end else if (length_ff == '0 || length_ff > MAX_IMAGE_BYTES
                   || length_ff[1:0] != 2'b00) begin
         code = F_LENGTH;
      end else if (length_ff > {{(WORD_W-SLOT_W){1'b0}}, room_ff}) begin
         code = F_SLOT;
      end else if (words_next == COUNT_MAX
                   || {{(WORD_W-COUNT_W){1'b0}}, words_next} != (length_ff >> 2)) begin
         code = F_COUNT;
      end else if (crc_out != exp_crc_ff) begin
         code = F_CRC;
      end else begin
         code = ff_next;
      end
   end

   always_comb begin
      crc_in       = crc_ff;
      words_in     = words_ff;
      fault_in     = fault_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (s1_fire) begin
         if (s1_last_ff) begin
            crc_in       = ALL_ONES;
            words_in     = '0;
            fault_in     = F_OK;
            rsp_valid_in = 1'b1;
            rsp_data_in  = {3'b000, crc_out, code, (code == F_OK)};
         end else begin
            crc_in   = crc_next;
            words_in = words_next;
            fault_in = ff_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         crc_ff       <= ALL_ONES;
         words_ff     <= '0;
         fault_ff     <= F_OK;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         crc_ff       <= crc_in;
         words_ff     <= words_in;
         fault_ff     <= fault_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_word_ff  <= s1_word_in;
      s1_last_ff  <= s1_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_ok_matches_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[0] == (rsp_data_ff[4:1] == F_OK)))
      else $error("pass flag disagrees with fault code");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_last_ff) |=>
         (crc_ff == ALL_ONES && words_ff == '0 && fault_ff == F_OK))
      else $error("stream state not cleared after final word");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_last_ff) |=> rsp_valid_ff)
      else $error("final word gave no result");

   a_no_fault_before_word: assert property (@(posedge clock) disable iff (reset)
      (words_ff == '0) |-> (fault_ff == F_OK))
      else $error("vector fault recorded with no word seen");

endmodule
